// ===== hdl/alc_pkg.sv =====
// shared types, constants and pair-check function for the adjacent label counter
// no dependencies
package alc_pkg;

  localparam int LABEL_W      = 8;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 8;
  localparam int MAX_COLUMNS_DEF = 128;
  localparam int EPOCH_W      = 8;

  localparam logic [LABEL_W-1:0]    TARGET_RESET  = 8'd0;
  localparam logic [LABEL_W-1:0]    BACKGND_RESET = 8'd46;
  localparam logic [CFG_DATA_W-1:0] COLUMNS_RESET = 8'd128;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TARGET  = 2'd0,
    REG_BACKGND = 2'd1,
    REG_COLUMNS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic               valid;
    logic [LABEL_W-1:0] label;
  } mark_t;

  // one adjacent pair: mark the partner of a target pixel unless it is excluded
  function automatic mark_t pair_mark(input logic               pair_en,
                                      input logic [LABEL_W-1:0] a,
                                      input logic [LABEL_W-1:0] b,
                                      input logic [LABEL_W-1:0] target,
                                      input logic [LABEL_W-1:0] backgnd);
    mark_t m;
    m.label = (b == target) ? a : b;
    m.valid = pair_en && ((a == target) || (b == target)) &&
              (m.label != target) && (m.label != backgnd);
    return m;
  endfunction

endpackage

// ===== hdl/adjacent_label_counter.sv =====
// top level of the adjacent label counter: raster position, line store, label set
// depends on alc_pkg, alc_line_mem, alc_label_set
//
//   channel | dir | handshake           | payload
//   in_     | in  | in_tvalid/in_tready | tdata = pixel_label, tlast = end_of_image
//   out_    | out | out_tvalid/tready   | tdata = neighbor_label_count
//   cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one pixel per cycle unless halted; the line store is read at accept, pair checks
// and tag ram accesses follow in the pair check stage, tag compare and count in the
// tag compare stage, and the output register holds the count. the pipeline halts
// while the tag ram is cleared, after reset and after every 255th image, and backs
// up to the input while a last pixel waits behind an unaccepted count.
// synchronous reset clears position, row flag, stages and output; no line store clear
module adjacent_label_counter import alc_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [LABEL_W-1:0]     in_tdata,   // pixel_label
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [LABEL_W-1:0]     out_tdata,  // neighbor_label_count
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW   = $clog2(MAX_COLUMNS);
  localparam int CL   = $clog2(MAX_COLUMNS + 1);
  localparam int CNTW = (CL > CFG_DATA_W) ? CL : CFG_DATA_W;

  logic [LABEL_W-1:0]    target_r;
  logic [LABEL_W-1:0]    backgnd_r;
  logic [CFG_DATA_W-1:0] columns_r;

  logic [CW-1:0]      col_r;
  logic [CW-1:0]      col_nxt;
  logic               first_r;
  logic               first_nxt;
  logic [LABEL_W-1:0] left_r;

  logic               s1_valid_r;
  logic [LABEL_W-1:0] s1_pix_r;
  logic [LABEL_W-1:0] s1_left_r;
  logic               s1_first_r;
  logic               s1_colnz_r;
  logic               s1_last_r;
  logic               s1_adv;

  logic               s2_valid_r;
  logic               s2_last_r;
  logic               s2_adv;
  logic               set_ready;

  logic               out_valid_r;
  logic [LABEL_W-1:0] out_data_r;

  logic               in_acc;
  logic [CNTW-1:0]    cols_eff;
  logic [CNTW-1:0]    col_inc;
  logic [LABEL_W-1:0] prev_pix;
  mark_t              mark_v;
  mark_t              mark_h;
  logic [LABEL_W-1:0] result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= TARGET_RESET;
      backgnd_r <= BACKGND_RESET;
      columns_r <= COLUMNS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TARGET:  target_r  <= cfg_data;
        REG_BACKGND: backgnd_r <= cfg_data;
        REG_COLUMNS: columns_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s2_adv    = s2_valid_r && (!s2_last_r || !out_valid_r || out_tready);
  assign s1_adv    = s1_valid_r && set_ready && (!s2_valid_r || s2_adv);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // raster position
  always_comb begin
    cols_eff = CNTW'(columns_r);
    if (cols_eff == '0) begin
      cols_eff = CNTW'(1);
    end else if (cols_eff > CNTW'(MAX_COLUMNS)) begin
      cols_eff = CNTW'(MAX_COLUMNS);
    end
    col_inc   = CNTW'(col_r) + CNTW'(1);
    col_nxt   = col_inc[CW-1:0];
    first_nxt = first_r;
    if (col_inc >= cols_eff) begin
      col_nxt   = '0;
      first_nxt = 1'b0;
    end
    if (in_tlast) begin
      col_nxt   = '0;
      first_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      first_r <= 1'b1;
      left_r  <= '0;
    end else if (in_acc) begin
      col_r   <= col_nxt;
      first_r <= first_nxt;
      left_r  <= in_tlast ? '0 : in_tdata;
    end
  end

  alc_line_mem #(
    .DEPTH (MAX_COLUMNS),
    .AW    (CW)
  ) u_line_mem (
    .clk   (clk),
    .en    (in_acc),
    .addr  (col_r),
    .wdata (in_tdata),
    .rdata (prev_pix)
  );

  // pair check stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r   <= in_tdata;
      s1_left_r  <= left_r;
      s1_first_r <= first_r;
      s1_colnz_r <= (col_r != '0);
      s1_last_r  <= in_tlast;
    end
  end

  assign mark_v = pair_mark(!s1_first_r, prev_pix, s1_pix_r, target_r, backgnd_r);
  assign mark_h = pair_mark(s1_colnz_r, s1_left_r, s1_pix_r, target_r, backgnd_r);

  // tag compare and count stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_r <= 1'b1;
    end else if (s2_adv) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_last_r <= s1_last_r;
    end
  end

  alc_label_set u_label_set (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_adv),
    .last        (s1_last_r),
    .mark_v      (mark_v),
    .mark_h      (mark_h),
    .retire      (s2_adv),
    .retire_last (s2_last_r),
    .ready       (set_ready),
    .result      (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv && s2_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_last_r) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/alc_line_mem.sv =====
// line store holding the previous image row, one label per column
// read-first synchronous ram with a registered read port; uses alc_pkg
module alc_line_mem import alc_pkg::*; #(
  parameter int DEPTH = MAX_COLUMNS_DEF,
  parameter int AW    = $clog2(MAX_COLUMNS_DEF)
) (
  input  logic               clk,
  input  logic               en,
  input  logic [AW-1:0]      addr,
  input  logic [LABEL_W-1:0] wdata,
  output logic [LABEL_W-1:0] rdata
);

  logic [LABEL_W-1:0] mem [DEPTH];
  logic [LABEL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r    <= mem[addr];
      mem[addr]  <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/alc_label_set.sv =====
// set of marked labels kept as image tags in a two-port ram, with a running count
// a clearing pass runs after reset and whenever the image tag wraps; uses alc_pkg
module alc_label_set import alc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               last,
  input  mark_t              mark_v,
  input  mark_t              mark_h,
  input  logic               retire,
  input  logic               retire_last,
  output logic               ready,
  output logic [LABEL_W-1:0] result
);

  localparam int SET_N   = 1 << LABEL_W;
  localparam int SWEEP_W = LABEL_W - 1;

  logic [EPOCH_W-1:0] tag_mem [SET_N];
  logic [EPOCH_W-1:0] tag_a_r;
  logic [EPOCH_W-1:0] tag_b_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [EPOCH_W-1:0] chk_epoch_r;
  logic               chk_a_r;
  logic               chk_b_r;
  logic               sweep_r;
  logic [SWEEP_W-1:0] sweep_cnt_r;
  logic [LABEL_W-1:0] count_r;

  logic               keep_h;
  logic               rd_a;
  logic               rd_b;
  logic               wr_a;
  logic               wr_b;
  logic [LABEL_W-1:0] addr_a;
  logic [LABEL_W-1:0] addr_b;
  logic [EPOCH_W-1:0] wdata;
  logic               new_a;
  logic               new_b;

  always_comb begin
    // both pairs naming the same label use port a only
    keep_h = mark_h.valid && !(mark_v.valid && (mark_v.label == mark_h.label));
    rd_a   = !sweep_r && step && mark_v.valid;
    rd_b   = !sweep_r && step && keep_h;
    wr_a   = sweep_r || rd_a;
    wr_b   = sweep_r || rd_b;
    addr_a = sweep_r ? {sweep_cnt_r, 1'b0} : mark_v.label;
    addr_b = sweep_r ? {sweep_cnt_r, 1'b1} : mark_h.label;
    wdata  = sweep_r ? '0 : epoch_r;
    new_a  = chk_a_r && (tag_a_r != chk_epoch_r);
    new_b  = chk_b_r && (tag_b_r != chk_epoch_r);
    result = count_r + LABEL_W'(new_a) + LABEL_W'(new_b);
  end

  assign ready = !sweep_r;

  // read-first tag ram, the old tag tells whether the label is new
  always_ff @(posedge clk) begin
    if (rd_a) begin
      tag_a_r <= tag_mem[addr_a];
    end
    if (rd_b) begin
      tag_b_r <= tag_mem[addr_b];
    end
    if (wr_a) begin
      tag_mem[addr_a] <= wdata;
    end
    if (wr_b) begin
      tag_mem[addr_b] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_a_r <= 1'b0;
      chk_b_r <= 1'b0;
    end else if (step) begin
      chk_a_r <= rd_a;
      chk_b_r <= rd_b;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      chk_epoch_r <= epoch_r;
    end
  end

  // image tag and clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
      epoch_r     <= EPOCH_W'(1);
    end else if (sweep_r) begin
      sweep_cnt_r <= sweep_cnt_r + SWEEP_W'(1);
      if (sweep_cnt_r == '1) begin
        sweep_r <= 1'b0;
      end
    end else if (step && last) begin
      if (epoch_r == '1) begin
        sweep_r <= 1'b1;
        epoch_r <= EPOCH_W'(1);
      end else begin
        epoch_r <= epoch_r + EPOCH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (retire) begin
      count_r <= retire_last ? '0 : result;
    end
  end

endmodule
